/* rtl/gtev_pkg.sv */
// ----------------------------------------------------------------------------
// gtev_pkg: shared types and constants of the glyph table entry validator
// Error codes, register indexes, reset values and the queue entry layout.
// ----------------------------------------------------------------------------
package gtev_pkg;

  // error codes, first failing check wins
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_ZERO_CODE     = 3'd1;
  localparam logic [2:0] ERR_NOT_RISING    = 3'd2;
  localparam logic [2:0] ERR_ZERO_SIZE     = 3'd3;
  localparam logic [2:0] ERR_PITCH_SHORT   = 3'd4;
  localparam logic [2:0] ERR_ROWS_SHORT    = 3'd5;
  localparam logic [2:0] ERR_OUT_OF_REGION = 3'd6;
  localparam logic [2:0] ERR_EARLIER       = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_PIXEL_DEPTH     = 2'd0;
  localparam logic [1:0] CFG_ROW_REGION_SIZE = 2'd1;
  localparam logic [1:0] CFG_ROW_REGION_BASE = 2'd2;

  localparam logic [2:0] PIXEL_DEPTH_RESET = 3'd1;

  // queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // classified entry handed from front to back
  typedef struct packed {
    logic        first_entry;
    logic        code_zero;
    logic [31:0] code_point;
    logic [2:0]  static_err;   // size, pitch, rows and region checks
    logic [31:0] row_address;
  } entry_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
  } queue_status_t;

endpackage

/* rtl/gtev_if.sv */
// ----------------------------------------------------------------------------
// gtev_if: stream channels of the glyph table entry validator
// Entry channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface gtev_in_if;
  logic        valid;
  logic        ready;
  logic        first_entry;
  logic [31:0] code_point;
  logic [31:0] row_start;
  logic [31:0] row_bytes_total;
  logic [7:0]  glyph_width;
  logic [7:0]  glyph_height;
  logic [7:0]  row_pitch;

  modport source (
    output valid, first_entry, code_point, row_start, row_bytes_total,
           glyph_width, glyph_height, row_pitch,
    input  ready
  );
  modport sink (
    input  valid, first_entry, code_point, row_start, row_bytes_total,
           glyph_width, glyph_height, row_pitch,
    output ready
  );
endinterface

interface gtev_out_if;
  logic        valid;
  logic        ready;
  logic        entry_ok;
  logic [2:0]  error_code;
  logic [31:0] row_address;

  modport source (
    output valid, entry_ok, error_code, row_address,
    input  ready
  );
  modport sink (
    input  valid, entry_ok, error_code, row_address,
    output ready
  );
endinterface

/* rtl/gtev_front.sv */
// ----------------------------------------------------------------------------
// gtev_front: entry classifier
// Accepts entry beats and runs the checks that do not depend on history.
// ----------------------------------------------------------------------------
module gtev_front (
  gtev_in_if.sink              in_chan,
  input  logic [2:0]           pixel_depth,
  input  logic [31:0]          row_region_size,
  input  logic [31:0]          row_region_base,
  input  gtev_pkg::queue_status_t q_status,
  output logic                 push,
  output gtev_pkg::entry_t     push_data
);
  import gtev_pkg::*;

  logic [10:0] pix_bits;
  logic [11:0] pix_bits_round;
  logic [8:0]  need_pitch;
  logic [15:0] need_rows;
  logic [31:0] region_left;
  logic        size_zero;
  logic        pitch_short;
  logic        rows_short;
  logic        out_region;

  // accept while the queue has room
  assign in_chan.ready = !q_status.full;
  assign push          = in_chan.valid && !q_status.full;

  // minimum pitch and row byte count
  assign pix_bits       = 11'(in_chan.glyph_width) * 11'(pixel_depth);
  assign pix_bits_round = 12'(pix_bits) + 12'd7;
  assign need_pitch     = pix_bits_round[11:3];
  assign need_rows      = 16'(in_chan.glyph_height) * 16'(in_chan.row_pitch);

  // row span against the region
  assign region_left = row_region_size - in_chan.row_start;

  assign size_zero   = (in_chan.glyph_width == 8'd0) || (in_chan.glyph_height == 8'd0);
  assign pitch_short = {1'b0, in_chan.row_pitch} < need_pitch;
  assign rows_short  = in_chan.row_bytes_total < {16'd0, need_rows};
  assign out_region  = (in_chan.row_start > row_region_size) ||
                       (in_chan.row_bytes_total > region_left);

  // pack the classified entry
  always_comb begin
    push_data.first_entry = in_chan.first_entry;
    push_data.code_zero   = (in_chan.code_point == 32'd0);
    push_data.code_point  = in_chan.code_point;
    push_data.row_address = row_region_base + in_chan.row_start;
    if (size_zero) begin
      push_data.static_err = ERR_ZERO_SIZE;
    end else if (pitch_short) begin
      push_data.static_err = ERR_PITCH_SHORT;
    end else if (rows_short) begin
      push_data.static_err = ERR_ROWS_SHORT;
    end else if (out_region) begin
      push_data.static_err = ERR_OUT_OF_REGION;
    end else begin
      push_data.static_err = ERR_NONE;
    end
  end

endmodule

/* rtl/gtev_queue.sv */
// ----------------------------------------------------------------------------
// gtev_queue: short entry queue
// Two-entry first-in first-out buffer between classifier and back end.
// ----------------------------------------------------------------------------
module gtev_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  gtev_pkg::entry_t        push_data,
  input  logic                    pop,
  output gtev_pkg::queue_status_t q_status,
  output logic                    head_valid,
  output gtev_pkg::entry_t        head_data
);
  import gtev_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign q_status.full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid    = (count_r != '0);
  assign head_data     = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/gtev_back.sv */
// ----------------------------------------------------------------------------
// gtev_back: history checks and result register
// Applies the rising code and sticky failure rules, updates the table
// history and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module gtev_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  gtev_pkg::entry_t head_data,
  output logic             pop,
  gtev_out_if.source       out_chan
);
  import gtev_pkg::*;

  logic [31:0] last_code_r, last_code_nxt;
  logic        failed_r, failed_nxt;
  logic        out_valid_r;
  logic        entry_ok_r;
  logic [2:0]  error_code_r;
  logic [31:0] row_address_r;
  logic [2:0]  err;

  // take the head when the result register is free or draining
  assign pop = head_valid && (!out_valid_r || out_chan.ready);

  // resolve the final code and the next history
  always_comb begin
    last_code_nxt = last_code_r;
    failed_nxt    = failed_r;
    if (failed_r && !head_data.first_entry) begin
      err = ERR_EARLIER;
    end else if (head_data.code_zero) begin
      err = ERR_ZERO_CODE;
    end else if (!head_data.first_entry && (head_data.code_point <= last_code_r)) begin
      err = ERR_NOT_RISING;
    end else begin
      err = head_data.static_err;
    end
    if (err == ERR_NONE) begin
      last_code_nxt = head_data.code_point;
      failed_nxt    = 1'b0;
    end else begin
      failed_nxt    = 1'b1;
    end
  end

  // control and history registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_code_r <= '0;
      failed_r    <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        last_code_r <= last_code_nxt;
        failed_r    <= failed_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      entry_ok_r    <= (err == ERR_NONE);
      error_code_r  <= err;
      row_address_r <= (err == ERR_NONE) ? head_data.row_address : 32'd0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.entry_ok    = entry_ok_r;
  assign out_chan.error_code  = error_code_r;
  assign out_chan.row_address = row_address_r;

endmodule

/* rtl/glyph_table_entry_validator_unit.sv */
// ----------------------------------------------------------------------------
// glyph_table_entry_validator_unit: glyph table entry checker
// Top level: configuration registers, classifier, queue and back end.
// ----------------------------------------------------------------------------
// Takes one decoded glyph entry beat per clock while the queue has room and
// returns one result beat per entry, in order, via the queue and the result
// register. The rate of one entry per cycle, when the output is not stalled,
// is set by the back end, which checks each code point against the last good
// one and updates the sticky failure flag; a two-entry queue lets the entry
// side go on while a result waits. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while no entry is in flight; the block does
// not enforce it. Unknown indexes are ignored. No clearing pass after reset.
module glyph_table_entry_validator_unit (
  input  logic        clk,
  input  logic        rst_n,
  gtev_in_if.sink     in_chan,
  gtev_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import gtev_pkg::*;

  logic [2:0]    pixel_depth_r;
  logic [31:0]   row_region_size_r;
  logic [31:0]   row_region_base_r;
  logic          push;
  entry_t        push_data;
  logic          pop;
  queue_status_t q_status;
  logic          head_valid;
  entry_t        head_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_depth_r     <= PIXEL_DEPTH_RESET;
      row_region_size_r <= '0;
      row_region_base_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_DEPTH:     pixel_depth_r     <= cfg_wdata[2:0];
        CFG_ROW_REGION_SIZE: row_region_size_r <= cfg_wdata;
        CFG_ROW_REGION_BASE: row_region_base_r <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  // classifier
  gtev_front u_front (
    .in_chan         (in_chan),
    .pixel_depth     (pixel_depth_r),
    .row_region_size (row_region_size_r),
    .row_region_base (row_region_base_r),
    .q_status        (q_status),
    .push            (push),
    .push_data       (push_data)
  );

  // entry queue
  gtev_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .q_status   (q_status),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // history checks and result
  gtev_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

/* tb/sv/tb_glyph_table_entry_validator_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_table_entry_validator_unit: testbench of the glyph table validator
// A scripted table of entries and register writes covers the checks, the
// sticky failure and the extremes. Random glyph tables then run under three
// handshake stall mixes. Every result beat is checked against a local predictor or a scripted verdict.
// ----------------------------------------------------------------------------
module tb_glyph_table_entry_validator_unit;
  import gtev_pkg::*;

  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int unsigned SEGMENTS = 12;
  localparam int unsigned SEGMENT_BEATS = 100;

  typedef struct packed {
    logic        first_entry;
    logic [31:0] code_point;
    logic [31:0] row_start;
    logic [31:0] row_bytes_total;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [7:0]  row_pitch;
  } glyph_entry_t;

  typedef struct packed {
    logic        entry_ok;
    logic [2:0]  error_code;
    logic [31:0] row_address;
  } entry_verdict_t;

  typedef enum bit {ROW_ENTRY, ROW_CFG} row_kind_t;

  typedef enum int unsigned {
    FAULT_ZERO_CODE, FAULT_STALE_CODE, FAULT_ZERO_SIZE,
    FAULT_NARROW_PITCH, FAULT_FEW_ROWS, FAULT_OUTSIDE
  } fault_kind_t;

  typedef struct {
    row_kind_t    kind;
    glyph_entry_t beat;
    logic [1:0]   cfg_idx;
    logic [31:0]  cfg_val;
    bit           typed;
    logic [2:0]   typed_err;
    logic [31:0]  typed_addr;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  gtev_in_if  in_bus ();
  gtev_out_if out_bus ();

  glyph_table_entry_validator_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // local copy of registers and table history
  logic [2:0]  mdl_depth;
  logic [31:0] mdl_region_size;
  logic [31:0] mdl_region_base;
  logic [31:0] mdl_last_code;
  logic        mdl_failed;

  entry_verdict_t pending_verdicts[$];
  script_row_t    directed_rows[$];
  int unsigned    in_idle_pct;
  int unsigned    out_idle_pct;
  int unsigned    mismatch_count = 0;
  int unsigned    verdicts_seen = 0;

  // random table generator state
  logic [31:0] gen_code;
  bit          gen_open;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected verdict of one entry, advances the table history
  function automatic entry_verdict_t judge_entry(glyph_entry_t e);
    entry_verdict_t v;
    logic [2:0]     err;
    logic [31:0]    need_pitch;
    logic [31:0]    need_rows;
    need_pitch = (32'(e.glyph_width) * 32'(mdl_depth) + 32'd7) / 32'd8;
    need_rows = 32'(e.glyph_height) * 32'(e.row_pitch);
    if (e.first_entry) mdl_failed = 1'b0;
    if (mdl_failed) begin
      err = ERR_EARLIER;
    end else begin
      if (e.code_point == 32'd0) err = ERR_ZERO_CODE;
      else if (!e.first_entry && e.code_point <= mdl_last_code) err = ERR_NOT_RISING;
      else if (e.glyph_width == 8'd0 || e.glyph_height == 8'd0) err = ERR_ZERO_SIZE;
      else if (32'(e.row_pitch) < need_pitch) err = ERR_PITCH_SHORT;
      else if (e.row_bytes_total < need_rows) err = ERR_ROWS_SHORT;
      else if (e.row_start > mdl_region_size ||
               e.row_bytes_total > mdl_region_size - e.row_start) err = ERR_OUT_OF_REGION;
      else err = ERR_NONE;
      if (err == ERR_NONE) mdl_last_code = e.code_point;
      else mdl_failed = 1'b1;
    end
    v.entry_ok = (err == ERR_NONE);
    v.error_code = err;
    v.row_address = (err == ERR_NONE) ? mdl_region_base + e.row_start : 32'd0;
    return v;
  endfunction

  function automatic void add_entry(bit first, logic [31:0] code, logic [31:0] start,
                                    logic [31:0] total, logic [7:0] w, logic [7:0] h,
                                    logic [7:0] p, bit typed = 1'b0,
                                    logic [2:0] err = ERR_NONE, logic [31:0] addr = 32'd0);
    script_row_t r;
    r.kind = ROW_ENTRY;
    r.beat = '{first, code, start, total, w, h, p};
    r.cfg_idx = CFG_PIXEL_DEPTH;
    r.cfg_val = 32'd0;
    r.typed = typed;
    r.typed_err = err;
    r.typed_addr = addr;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [31:0] val);
    script_row_t r;
    r.kind = ROW_CFG;
    r.beat = '0;
    r.cfg_idx = idx;
    r.cfg_val = val;
    r.typed = 1'b0;
    r.typed_err = ERR_NONE;
    r.typed_addr = 32'd0;
    directed_rows = {directed_rows, r};
  endfunction

  // one random entry: mostly well-formed tables, some faults, some noise
  function automatic glyph_entry_t next_random_entry();
    glyph_entry_t e;
    logic [31:0]  need_pitch;
    logic [31:0]  need_rows;
    if ($urandom_range(99) < 8) begin
      e.first_entry = 1'($urandom_range(1));
      e.code_point = $urandom;
      e.row_start = $urandom;
      e.row_bytes_total = $urandom;
      e.glyph_width = 8'($urandom);
      e.glyph_height = 8'($urandom);
      e.row_pitch = 8'($urandom);
      return e;
    end
    // new table when none is open, when codes run short, or at random
    e.first_entry = !gen_open || gen_code > 32'hFFE0_0000 || $urandom_range(15) == 0;
    if (e.first_entry)
      gen_code = ($urandom_range(3) == 0) ? $urandom_range(1, 64)
                                          : $urandom_range(1, 32'hFFE0_0000);
    else
      gen_code += ($urandom_range(3) == 0) ? $urandom_range(1, 1 << 20)
                                           : $urandom_range(1, 8);
    gen_open = 1'b1;
    e.code_point = gen_code;
    e.glyph_width = 8'($urandom_range(1, 255));
    e.glyph_height = $urandom_range(1) ? 8'($urandom_range(1, 255))
                                       : 8'($urandom_range(1, 8));
    need_pitch = (32'(e.glyph_width) * 32'(mdl_depth) + 32'd7) / 32'd8;
    e.row_pitch = 8'(need_pitch + $urandom_range(0, 3));
    need_rows = 32'(e.glyph_height) * 32'(e.row_pitch);
    e.row_bytes_total = need_rows + $urandom_range(0, 15);
    if (mdl_region_size >= e.row_bytes_total)
      e.row_start = ($urandom_range(7) == 0) ? mdl_region_size - e.row_bytes_total
                                             : $urandom_range(0, mdl_region_size -
                                                                 e.row_bytes_total);
    else
      e.row_start = $urandom;
    // occasional broken entry
    if ($urandom_range(99) < 12) begin
      case (fault_kind_t'($urandom_range(FAULT_ZERO_CODE, FAULT_OUTSIDE)))
        FAULT_ZERO_CODE: e.code_point = 32'd0;
        FAULT_STALE_CODE: e.code_point = mdl_last_code;
        FAULT_ZERO_SIZE: begin
          if ($urandom_range(1)) e.glyph_width = 8'd0;
          else e.glyph_height = 8'd0;
        end
        FAULT_NARROW_PITCH: if (need_pitch != 0) e.row_pitch = 8'(need_pitch - 1);
        FAULT_FEW_ROWS: if (need_rows != 0) e.row_bytes_total = need_rows - 32'd1;
        default: e.row_start = mdl_region_size - e.row_bytes_total + $urandom_range(1, 16);
      endcase
    end
    return e;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t: result beat %0d %s got 0x%0h want 0x%0h",
             $time, verdicts_seen, field, got, want);
  endtask

  // present one entry beat, predict its verdict once taken
  task automatic push_entry(glyph_entry_t e, bit typed = 1'b0,
                            logic [2:0] want_err = ERR_NONE,
                            logic [31:0] want_addr = 32'd0);
    entry_verdict_t v;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.first_entry     <= e.first_entry;
    in_bus.code_point      <= e.code_point;
    in_bus.row_start       <= e.row_start;
    in_bus.row_bytes_total <= e.row_bytes_total;
    in_bus.glyph_width     <= e.glyph_width;
    in_bus.glyph_height    <= e.glyph_height;
    in_bus.row_pitch       <= e.row_pitch;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    v = judge_entry(e);
    if (typed) begin
      v.entry_ok = (want_err == ERR_NONE);
      v.error_code = want_err;
      v.row_address = want_addr;
    end
    pending_verdicts = {pending_verdicts, v};
  endtask

  // drop valid and wait for every outstanding verdict
  task automatic settle_pipeline();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PIXEL_DEPTH:     mdl_depth = val[2:0];
      CFG_ROW_REGION_SIZE: mdl_region_size = val;
      CFG_ROW_REGION_BASE: mdl_region_base = val;
      default: ;
    endcase
  endtask

  // fresh register set for one random segment
  task automatic program_segment(int unsigned seg);
    logic [2:0]  depth;
    logic [31:0] size;
    logic [31:0] base;
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(2))
        0: depth = 3'd1;
        1: depth = 3'd2;
        default: depth = 3'd4;
      endcase
    end else begin
      depth = 3'($urandom_range(0, 7));
    end
    case (seg % 4)
      0: size = 32'hFFFF_FFFF;
      1: size = $urandom;
      2: size = $urandom_range(32'h1000, 32'h4_0000);
      default: size = $urandom_range(32'h10_0000, 32'h00FF_FFFF);
    endcase
    case (seg % 3)
      0: base = 32'hFFFF_FFFF;
      1: base = 32'd0;
      default: base = $urandom;
    endcase
    settle_pipeline();
    write_reg(CFG_PIXEL_DEPTH, ($urandom & 32'hFFFF_FFF8) | 32'(depth));
    write_reg(CFG_ROW_REGION_SIZE, size);
    write_reg(CFG_ROW_REGION_BASE, base);
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_INDEX, $urandom);
    gen_open = 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // result beat check against the oldest expectation
  always @(posedge clk) begin : result_check
    entry_verdict_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("unexpected beat", 32'(out_bus.error_code), 32'd0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_bus.entry_ok !== want.entry_ok)
          flag_mismatch("entry_ok", 32'(out_bus.entry_ok), 32'(want.entry_ok));
        if (out_bus.error_code !== want.error_code)
          flag_mismatch("error_code", 32'(out_bus.error_code), 32'(want.error_code));
        if (out_bus.row_address !== want.row_address)
          flag_mismatch("row_address", out_bus.row_address, want.row_address);
      end
      verdicts_seen++;
    end
  end

  initial begin : stimulus
    int unsigned seg;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_PIXEL_DEPTH;
    cfg_wdata              = 32'd0;
    in_bus.valid           = 1'b0;
    in_bus.first_entry     = 1'b0;
    in_bus.code_point      = 32'd0;
    in_bus.row_start       = 32'd0;
    in_bus.row_bytes_total = 32'd0;
    in_bus.glyph_width     = 8'd0;
    in_bus.glyph_height    = 8'd0;
    in_bus.row_pitch       = 8'd0;
    mdl_depth              = PIXEL_DEPTH_RESET;
    mdl_region_size        = 32'd0;
    mdl_region_base        = 32'd0;
    mdl_last_code          = 32'd0;
    mdl_failed             = 1'b0;
    gen_code               = 32'd0;
    gen_open               = 1'b0;
    in_idle_pct            = 28;
    out_idle_pct           = 47;

    // reset registers, no first entry yet
    add_entry(0, 32'd0, 32'd0, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_ZERO_CODE);
    add_entry(0, 32'd10, 32'd0, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_EARLIER);
    add_entry(1, 32'd10, 32'd0, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_OUT_OF_REGION);
    // full region, base wraps, depth written with junk upper bits
    add_cfg(CFG_PIXEL_DEPTH, 32'hFFFF_FFFC);
    add_cfg(CFG_ROW_REGION_SIZE, 32'hFFFF_FFFF);
    add_cfg(CFG_ROW_REGION_BASE, 32'hFFFF_FFFF);
    add_entry(1, 32'd1, 32'd1, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_NONE, 32'd0);
    add_entry(0, 32'd1, 32'd1, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_NOT_RISING);
    add_entry(1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1, 8'd255, 8'd255, 8'd128, 1,
              ERR_ROWS_SHORT);
    add_entry(1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255, 1,
              ERR_NONE, 32'hFFFF_FFFF);
    add_entry(0, 32'hFFFF_FFFF, 32'd0, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_NOT_RISING);
    add_entry(1, 32'd2, 32'd0, 32'd4, 8'd0, 8'd5, 8'd1, 1, ERR_ZERO_SIZE);
    add_entry(1, 32'd2, 32'd0, 32'd4, 8'd5, 8'd0, 8'd1, 1, ERR_ZERO_SIZE);
    add_entry(1, 32'd2, 32'd0, 32'd200, 8'd255, 8'd1, 8'd127, 1, ERR_PITCH_SHORT);
    add_entry(1, 32'd3, 32'hFFFF_FFFF, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_OUT_OF_REGION);
    // depth zero needs no pitch, span ending exactly at the region end
    add_cfg(CFG_PIXEL_DEPTH, 32'd0);
    add_cfg(CFG_ROW_REGION_SIZE, 32'h100);
    add_cfg(CFG_ROW_REGION_BASE, 32'h1000);
    add_entry(1, 32'd100, 32'd0, 32'h100, 8'd255, 8'd255, 8'd0);
    add_entry(0, 32'd101, 32'h100, 32'd0, 8'd1, 8'd1, 8'd0);
    add_entry(0, 32'd102, 32'h80, 32'h81, 8'd1, 8'd1, 8'd0);
    add_entry(0, 32'd200, 32'd0, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_EARLIER);
    // widest depth field
    add_cfg(CFG_PIXEL_DEPTH, 32'd7);
    add_cfg(CFG_ROW_REGION_SIZE, 32'h400);
    add_entry(1, 32'd50, 32'd0, 32'd448, 8'd255, 8'd2, 8'd224);
    add_entry(0, 32'd50, 32'd0, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_NOT_RISING);
    add_entry(1, 32'd51, 32'd0, 32'd255, 8'd255, 8'd1, 8'd223, 1, ERR_PITCH_SHORT);
    // unused index must leave the registers alone
    add_cfg(CFG_PIXEL_DEPTH, 32'd2);
    add_cfg(CFG_ROW_REGION_SIZE, 32'h1_0000);
    add_cfg(CFG_ROW_REGION_BASE, 32'h8000_0000);
    add_cfg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
    add_entry(1, 32'd7, 32'h10, 32'h20, 8'd8, 8'd8, 8'd2);
    add_entry(0, 32'd8, 32'hFFF0, 32'h10, 8'd8, 8'd8, 8'd2);
    add_entry(0, 32'd0, 32'd0, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_ZERO_CODE);
    add_entry(0, 32'd9, 32'd0, 32'd1, 8'd1, 8'd1, 8'd1, 1, ERR_EARLIER);
    add_entry(1, 32'h8000_0000, 32'd0, 32'hFF, 8'd255, 8'd1, 8'h40);
    add_entry(0, 32'h8000_0001, 32'd0, 32'hFE, 8'd1, 8'd255, 8'd1, 1, ERR_ROWS_SHORT);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle_pipeline();
        write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      end else begin
        push_entry(directed_rows[i].beat, directed_rows[i].typed,
                   directed_rows[i].typed_err, directed_rows[i].typed_addr);
      end
    end

    // random tables under three stall mixes
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        in_idle_pct = 28;
        out_idle_pct = 47;
      end else if (seg < 2 * SEGMENTS / 3) begin
        in_idle_pct = 47;
        out_idle_pct = 28;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      program_segment(seg);
      repeat (SEGMENT_BEATS) push_entry(next_random_entry());
    end

    settle_pipeline();
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
